>>> rtl/core/tdq_pkg.sv
// Package for the TDMA transmit queue: request, status and register codes,
// state encoding, frame number alignment constants and the result item. No dependencies.
package tdq_pkg;

  // Request codes carried in the slave-side tuser
  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_DEQUEUE = 2'd1,
    REQ_FLUSH   = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_TS_OFF = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_RSVD   = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TS_ENABLED = 2'd0,
    CFG_TCH_FULL   = 2'd1,
    CFG_TCH_HALF0  = 2'd2,
    CFG_TCH_HALF1  = 2'd3
  } cfg_idx_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_COMPACT,
    ST_RESULT
  } state_e;

  localparam int FN_BITS   = 22;
  localparam int FN_PERIOD = 26;
  localparam int FN_REM_W  = 5;
  localparam int CHAN_BITS = 6;

  // FACCH alignment of the 26-frame multiframe per half-rate subchannel
  localparam logic [FN_REM_W-1:0] H0_FN_A = 5'd0;
  localparam logic [FN_REM_W-1:0] H0_FN_B = 5'd8;
  localparam logic [FN_REM_W-1:0] H0_FN_C = 5'd17;
  localparam logic [FN_REM_W-1:0] H1_FN_A = 5'd1;
  localparam logic [FN_REM_W-1:0] H1_FN_B = 5'd9;
  localparam logic [FN_REM_W-1:0] H1_FN_C = 5'd18;

  // One result item
  typedef struct packed {
    logic [4:0]  flushed_count;
    logic [15:0] dropped_tag_second;
    logic [15:0] dropped_tag_first;
    logic [1:0]  dropped_count;
    logic        out_facch;
    logic [15:0] out_tag;
    logic        found;
    status_e     status;
  } result_t;

endpackage

>>> rtl/core/tdq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module tdq_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/core/tdq_mod26.sv
// Remainder of the TDMA frame number by the multiframe length, computed by a
// reciprocal multiplication with a registered quotient. Depends on tdq_pkg.
module tdq_mod26 import tdq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [FN_BITS-1:0]  value_i,
  output logic                done_o,
  output logic [FN_REM_W-1:0] rem_o
);

  // 2^27 / 26 rounded up gives the exact quotient for every 22-bit frame number
  localparam int          RECIP_SHIFT = 27;
  localparam logic [22:0] FN_RECIP    = 23'd5162221;
  localparam int          PROD_W      = FN_BITS + 23;
  localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;

  logic [FN_BITS-1:0]  val_q, val_d;
  logic [QUOT_W-1:0]   quot_q, quot_d;
  logic [FN_REM_W-1:0] rem_q, rem_d;
  logic [1:0]          cnt_q, cnt_d;
  logic [PROD_W-1:0]   prod;
  logic [FN_BITS:0]    back;

  // Estimate the quotient, then subtract its multiple of the period
  always_comb begin
    prod   = PROD_W'(val_q) * PROD_W'(FN_RECIP);
    back   = (FN_BITS+1)'(quot_q) * (FN_BITS+1)'(FN_PERIOD);
    val_d  = val_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      val_d = value_i;
      cnt_d = 2'd2;
    end else if (cnt_q == 2'd2) begin
      quot_d = prod[PROD_W-1 -: QUOT_W];
      cnt_d  = 2'd1;
    end else if (cnt_q == 2'd1) begin
      rem_d = FN_REM_W'((FN_BITS+1)'(val_q) - back);
      cnt_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = cnt_q == 2'd0;
  assign rem_o  = rem_q;

endmodule

>>> rtl/core/tdma_tx_queue_facch_priority.sv
// Top level of the per-timeslot TDMA transmit queue with FACCH priority.
// Depends on tdq_pkg, tdq_ram and tdq_mod26.
//
//  channel  | direction | handshake              | content
//  ---------+-----------+------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid/tready   | request (tuser kind, tdata args)
//  m_axis   | out       | m_axis_tvalid/tready   | result of one request
//  cfg      | in        | cfg_we_i               | register index and data
//
//  Push, flush and rejected requests go from DECODE straight to RESULT.
//  Dequeue scans the queue once to locate entries and a second time to compact
//  it through the single entry RAM; the first pass also waits for the remainder
//  unit to finish before it ends.
//  Reset clears fill counts and control registers; entry RAM contents need no clearing.
//  One request is in flight at a time; a result waits in the output register.
module tdma_tx_queue_facch_priority import tdq_pkg::*; #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int TIMESLOT_COUNT = 8,
  parameter int TAG_BITS       = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] timeslot, [8:3] chan_type, [9] is_facch, [25:10] frame_tag,
  // [47:26] frame_number
  input  logic [47:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [2] found, [18:3] out_tag, [19] out_facch,
  // [21:20] dropped_count, [37:22] dropped_tag_first,
  // [53:38] dropped_tag_second, [58:54] flushed_count, [63:59] zero
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int IW  = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int TSW = (TIMESLOT_COUNT > 1) ? $clog2(TIMESLOT_COUNT) : 1;
  localparam int RD  = TIMESLOT_COUNT * QUEUE_DEPTH;
  localparam int AW  = $clog2(RD);
  localparam int EW  = TAG_BITS + CHAN_BITS + 1;

  // Configuration registers
  logic [7:0]           ts_en_q;
  logic [CHAN_BITS-1:0] code_full_q, code_h0_q, code_h1_q;

  // Captured request
  req_e                 req_q;
  logic [2:0]           ts_q;
  logic [CHAN_BITS-1:0] chan_q;
  logic                 facch_q;
  logic [15:0]          tag_q;
  logic [FN_BITS-1:0]   fn_q;

  state_e state_q, state_d;
  logic [FW-1:0] fill_q [TIMESLOT_COUNT];
  logic [FW-1:0] rd_idx_q, wp_q;
  logic [IW-1:0] pend_idx_q;
  logic          pend_q;

  // Located entries
  logic                f_v_q, s0_v_q, s1_v_q, a_v_q, a_facch_q;
  logic [IW-1:0]       f_idx_q, s0_idx_q, s1_idx_q, a_idx_q;
  logic [TAG_BITS-1:0] f_tag_q, s0_tag_q, s1_tag_q, a_tag_q;

  result_t res_q;
  logic    out_valid_q;
  logic [63:0] out_data_q;

  logic [TSW-1:0] ts_idx;
  logic           ts_ok;
  logic [FW-1:0]  fill_cur;
  logic           s_acc;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_widx;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0] ram_waddr, ram_raddr;

  logic                mod_start, mod_done;
  logic [FN_REM_W-1:0] fn_rem;

  logic is_full, is_half, allow;
  logic rm_f, rm_s0, rm_s1, rm_a, removed;
  logic [2:0] n_rem;
  logic [EW-1:0] new_entry;
  logic          e_facch;
  logic [CHAN_BITS-1:0] e_chan;
  logic [TAG_BITS-1:0]  e_tag;
  logic          e_match;
  logic          out_free, scan_end, compact_end;
  result_t       deq_res;
  result_t       dec_res;

  assign ts_idx   = ts_q[TSW-1:0];
  assign ts_ok    = int'(ts_q) < TIMESLOT_COUNT;
  assign fill_cur = fill_q[ts_idx];
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign new_entry = {facch_q, chan_q, TAG_BITS'(tag_q)};
  assign e_facch   = ram_rdata[EW-1];
  assign e_chan    = ram_rdata[EW-2 -: CHAN_BITS];
  assign e_tag     = ram_rdata[TAG_BITS-1:0];
  assign e_match   = e_chan == chan_q;

  assign ram_waddr = AW'(int'(ts_idx) * QUEUE_DEPTH + int'(ram_widx));
  assign ram_raddr = AW'(int'(ts_idx) * QUEUE_DEPTH + int'(rd_idx_q[IW-1:0]));

  tdq_ram #(
    .WIDTH (EW),
    .DEPTH (RD)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tdq_mod26 u_fn_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (fn_q),
    .done_o  (mod_done),
    .rem_o   (fn_rem)
  );

  // Select which located entries a dequeue removes
  always_comb begin
    is_full = chan_q == code_full_q;
    is_half = !is_full && (chan_q == code_h0_q || chan_q == code_h1_q);
    allow   = (chan_q == code_h0_q &&
               (fn_rem == H0_FN_A || fn_rem == H0_FN_B || fn_rem == H0_FN_C)) ||
              (chan_q == code_h1_q &&
               (fn_rem == H1_FN_A || fn_rem == H1_FN_B || fn_rem == H1_FN_C));
    rm_f    = f_v_q && (is_full || (is_half && allow));
    rm_s0   = s0_v_q && (is_full || is_half);
    rm_s1   = s1_v_q && is_half && allow && f_v_q;
    rm_a    = a_v_q && !is_full && !is_half;
    n_rem   = 3'(rm_f) + 3'(rm_s0) + 3'(rm_s1) + 3'(rm_a);
    removed = (rm_f && pend_idx_q == f_idx_q) || (rm_s0 && pend_idx_q == s0_idx_q) ||
              (rm_s1 && pend_idx_q == s1_idx_q) || (rm_a && pend_idx_q == a_idx_q);
  end

  // Build the dequeue result
  always_comb begin
    deq_res        = '0;
    deq_res.status = STAT_OK;
    deq_res.found  = rm_f || rm_s0 || rm_a;
    if (rm_f) begin
      deq_res.out_tag   = 16'(f_tag_q);
      deq_res.out_facch = 1'b1;
      deq_res.dropped_count = 2'(rm_s0) + 2'(rm_s1);
      if (rm_s0) begin
        deq_res.dropped_tag_first = 16'(s0_tag_q);
      end
      if (rm_s1) begin
        deq_res.dropped_tag_second = 16'(s1_tag_q);
      end
    end else if (rm_a) begin
      deq_res.out_tag   = 16'(a_tag_q);
      deq_res.out_facch = a_facch_q;
    end else if (rm_s0) begin
      deq_res.out_tag = 16'(s0_tag_q);
    end
  end

  // Build the result of a request that needs no scan
  always_comb begin
    dec_res = '0;
    if (req_q == REQ_NONE) begin
      dec_res.status = STAT_OK;
    end else if (!ts_ok) begin
      dec_res.status = STAT_TS_OFF;
    end else if (req_q == REQ_PUSH) begin
      if (!ts_en_q[ts_q]) dec_res.status = STAT_TS_OFF;
      else if (!ram_we) dec_res.status = STAT_FULL;
    end else if (req_q == REQ_FLUSH) begin
      dec_res.flushed_count = 5'(fill_cur);
    end
  end

  assign scan_end    = !ram_re && !pend_q && mod_done;
  assign compact_end = !ram_re && !pend_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_acc) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (req_q == REQ_DEQUEUE && ts_ok) state_d = ST_SCAN;
        else state_d = ST_RESULT;
      end
      ST_SCAN: begin
        if (scan_end) state_d = ST_COMPACT;
      end
      ST_COMPACT: begin
        if (compact_end) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_widx      = wp_q[IW-1:0];
    ram_wdata     = ram_rdata;
    mod_start     = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_DECODE: begin
        mod_start = req_q == REQ_DEQUEUE && ts_ok;
        if (req_q == REQ_PUSH && ts_ok && ts_en_q[ts_q] &&
            fill_cur < FW'(QUEUE_DEPTH)) begin
          ram_we    = 1'b1;
          ram_widx  = fill_cur[IW-1:0];
          ram_wdata = new_entry;
        end
      end
      ST_SCAN: ram_re = rd_idx_q < fill_cur;
      ST_COMPACT: begin
        ram_re = rd_idx_q < fill_cur;
        ram_we = pend_q && !removed;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      ts_en_q     <= '0;
      code_full_q <= 6'd1;
      code_h0_q   <= 6'd2;
      code_h1_q   <= 6'd3;
      for (int t = 0; t < TIMESLOT_COUNT; t++) begin
        fill_q[t] <= '0;
      end
    end else begin
      state_q <= state_d;
      pend_q  <= ram_re;
      // Configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TS_ENABLED: ts_en_q     <= cfg_data_i;
          CFG_TCH_FULL:   code_full_q <= cfg_data_i[CHAN_BITS-1:0];
          CFG_TCH_HALF0:  code_h0_q   <= cfg_data_i[CHAN_BITS-1:0];
          CFG_TCH_HALF1:  code_h1_q   <= cfg_data_i[CHAN_BITS-1:0];
          default: ;
        endcase
      end
      // Update the fill count
      if (state_q == ST_DECODE && ts_ok) begin
        if (ram_we) fill_q[ts_idx] <= fill_cur + 1'b1;
        else if (req_q == REQ_FLUSH) fill_q[ts_idx] <= '0;
      end
      if (state_q == ST_COMPACT && compact_end) begin
        fill_q[ts_idx] <= fill_cur - FW'(n_rem);
      end
      // Hold the result until taken
      if (state_q == ST_RESULT && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Request capture, scan and compaction datapath
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      req_q   <= req_e'(s_axis_tuser);
      ts_q    <= s_axis_tdata[2:0];
      chan_q  <= s_axis_tdata[8:3];
      facch_q <= s_axis_tdata[9];
      tag_q   <= s_axis_tdata[25:10];
      fn_q    <= s_axis_tdata[47:26];
    end
    pend_idx_q <= rd_idx_q[IW-1:0];
    if (ram_re) rd_idx_q <= rd_idx_q + 1'b1;
    case (state_q)
      ST_DECODE: begin
        res_q    <= dec_res;
        rd_idx_q <= '0;
        f_v_q    <= 1'b0;
        s0_v_q   <= 1'b0;
        s1_v_q   <= 1'b0;
        a_v_q    <= 1'b0;
      end
      ST_SCAN: begin
        // Locate the first FACCH, first two speech and first matching entries
        if (pend_q && e_match) begin
          if (e_facch && !f_v_q) begin
            f_v_q   <= 1'b1;
            f_idx_q <= pend_idx_q;
            f_tag_q <= e_tag;
          end
          if (!e_facch && !s0_v_q) begin
            s0_v_q   <= 1'b1;
            s0_idx_q <= pend_idx_q;
            s0_tag_q <= e_tag;
          end else if (!e_facch && !s1_v_q) begin
            s1_v_q   <= 1'b1;
            s1_idx_q <= pend_idx_q;
            s1_tag_q <= e_tag;
          end
          if (!a_v_q) begin
            a_v_q     <= 1'b1;
            a_idx_q   <= pend_idx_q;
            a_tag_q   <= e_tag;
            a_facch_q <= e_facch;
          end
        end
        if (scan_end) begin
          rd_idx_q <= '0;
          wp_q     <= '0;
        end
      end
      ST_COMPACT: begin
        // Advance the write pointer over kept entries
        if (ram_we) wp_q <= wp_q + 1'b1;
        if (compact_end) res_q <= deq_res;
      end
      ST_RESULT: begin
        if (out_free) begin
          out_data_q <= {5'd0, res_q.flushed_count, res_q.dropped_tag_second,
                         res_q.dropped_tag_first, res_q.dropped_count,
                         res_q.out_facch, res_q.out_tag, res_q.found, res_q.status};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Compaction never overwrites an entry not yet read
  a_wp_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMPACT && ram_we) |-> (wp_q[IW-1:0] <= pend_idx_q))
    else $error("compaction write overtakes read");

  // Fill count stays within the queue depth
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (fill_cur <= FW'(QUEUE_DEPTH)))
    else $error("queue fill beyond depth");

  // A dequeue removes no more entries than the queue holds
  a_remove_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMPACT && compact_end) |-> (FW'(n_rem) <= fill_cur))
    else $error("removal count beyond fill");

  // Remainder unit is finished whenever a request may be accepted
  a_mod_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> mod_done)
    else $error("remainder unit busy while idle");

endmodule
